// File: rtl/shm_pkg.sv
// Shared types, constants and the phase table for the half-step angle mover.
`timescale 1ns / 1ps

package shm_pkg;

	localparam int OP_W      = 2;
	localparam int DEG_W     = 12;
	localparam int PERIOD_W  = 8;
	localparam int TICK_W    = 8;
	localparam int PHASE_W   = 3;
	localparam int CYCLES_W  = 13;
	localparam int COILS_W   = 4;

	// Operation codes of an input item.
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	localparam logic [PHASE_W-1:0]  LAST_PHASE   = 3'd7;
	localparam logic [TICK_W-1:0]   SETTLE_TICKS = 8'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd1;

	// 512 * deg / 360 = 64 * deg / 45; ceil(2^24 / 45), exact for every 12-bit angle.
	localparam int                RECIP_W   = 19;
	localparam logic [RECIP_W-1:0] RECIP_45 = 19'd372828;
	localparam int                PROD_W    = DEG_W + RECIP_W;
	localparam int                QUOT_LSB  = 18;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STEP   = 2'd1,
		MODE_SETTLE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [COILS_W-1:0] coils;
		logic               busy;
		logic               last_cw;
		logic               rejected;
	} result_t;

	// Coil pattern for a phase: clockwise A,AB,B,BC,C,CD,D,DA; anticlockwise mirrored.
	function automatic logic [COILS_W-1:0] seq_pattern(input logic cw,
	                                                  input logic [PHASE_W-1:0] idx);
		logic [COILS_W-1:0] pat;
		pat = 4'h0;
		if (cw) begin
			unique case (idx)
				3'd0: pat = 4'h1;
				3'd1: pat = 4'h3;
				3'd2: pat = 4'h2;
				3'd3: pat = 4'h6;
				3'd4: pat = 4'h4;
				3'd5: pat = 4'hC;
				3'd6: pat = 4'h8;
				default: pat = 4'h9;
			endcase
		end else begin
			unique case (idx)
				3'd0: pat = 4'h8;
				3'd1: pat = 4'hC;
				3'd2: pat = 4'h4;
				3'd3: pat = 4'h6;
				3'd4: pat = 4'h2;
				3'd5: pat = 4'h3;
				3'd6: pat = 4'h1;
				default: pat = 4'h9;
			endcase
		end
		return pat;
	endfunction

	// Full cycles for an angle: floor(64 * deg / 45) + 1.
	function automatic logic [CYCLES_W-1:0] cycles_for(input logic [DEG_W-1:0] deg);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(deg) * PROD_W'(RECIP_45);
		return prod[QUOT_LSB +: CYCLES_W] + CYCLES_W'(1);
	endfunction

endpackage

// File: rtl/shm_core.sv
// Sequencer state and per-item update of the half-step angle mover.
`timescale 1ns / 1ps

module shm_core import shm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [OP_W-1:0]     operation,
	input  logic                clockwise,
	input  logic [DEG_W-1:0]    degrees,
	input  logic [PERIOD_W-1:0] step_period,
	output result_t             res_d
);

	mode_t                mode_q, mode_d;
	logic [PHASE_W-1:0]   phase_q, phase_d;
	logic [CYCLES_W-1:0]  cycles_q, cycles_d;
	logic [TICK_W-1:0]    tick_q, tick_d, tick_inc;
	logic                 dir_q, dir_d;
	logic                 last_dir_q, last_dir_d;
	logic [COILS_W-1:0]   coil_q, coil_d;
	logic                 rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_q    <= '0;
			cycles_q   <= '0;
			tick_q     <= '0;
			dir_q      <= 1'b1;
			last_dir_q <= 1'b1;
			coil_q     <= '0;
		end else if (adv) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			cycles_q   <= cycles_d;
			tick_q     <= tick_d;
			dir_q      <= dir_d;
			last_dir_q <= last_dir_d;
			coil_q     <= coil_d;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		cycles_d   = cycles_q;
		tick_d     = tick_q;
		dir_d      = dir_q;
		last_dir_d = last_dir_q;
		coil_d     = coil_q;
		rej        = 1'b0;
		tick_inc   = tick_q + TICK_W'(1);

		unique case (operation)
			OP_TICK: begin
				unique case (mode_q)
					MODE_STEP: begin
						tick_d = tick_inc;
						if (tick_inc >= step_period) begin
							tick_d = '0;
							if (phase_q == LAST_PHASE) begin
								cycles_d = cycles_q - CYCLES_W'(1);
								// last cycle done: hold the final pattern and settle
								if (cycles_q == CYCLES_W'(1)) begin
									mode_d = MODE_SETTLE;
								end else begin
									phase_d = '0;
									coil_d  = seq_pattern(dir_q, '0);
								end
							end else begin
								phase_d = phase_q + PHASE_W'(1);
								coil_d  = seq_pattern(dir_q, phase_q + PHASE_W'(1));
							end
						end
					end
					MODE_SETTLE: begin
						tick_d = tick_inc;
						if (tick_inc >= SETTLE_TICKS) begin
							last_dir_d = dir_q;
							coil_d     = '0;
							mode_d     = MODE_IDLE;
							phase_d    = '0;
							cycles_d   = '0;
							tick_d     = '0;
						end
					end
					default: ;
				endcase
			end
			OP_START: begin
				if (mode_q != MODE_IDLE) begin
					rej = 1'b1;
				end else begin
					dir_d    = clockwise;
					cycles_d = cycles_for(degrees);
					phase_d  = '0;
					tick_d   = '0;
					mode_d   = MODE_STEP;
					coil_d   = seq_pattern(clockwise, '0);
				end
			end
			OP_STOP: begin
				coil_d   = '0;
				mode_d   = MODE_IDLE;
				phase_d  = '0;
				cycles_d = '0;
				tick_d   = '0;
			end
			default: ;
		endcase

		res_d.coils    = coil_d;
		res_d.busy     = (mode_d != MODE_IDLE);
		res_d.last_cw  = last_dir_d;
		res_d.rejected = rej;
	end

endmodule

// File: rtl/stepper_half_step_angle_mover.sv
// Top level of the half-step angle mover: input register, sequencer, result register.
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, then the result register, and is
// presented on the result ports when the result register takes it; out_valid rises with it.
// Throughput: one item per cycle unless a result stalls; the sequencer update is a single
// pass through the state logic, the angle-to-cycle count being one constant multiply in it.
// Backpressure: a waiting result holds the item in the input register and drops in_ready;
// an empty input register can still take one item while a result waits.
// Reset: coils off, idle, step_period 1, direction and last direction clockwise.

module stepper_half_step_angle_mover import shm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// item input
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic                clockwise,
	input  logic [DEG_W-1:0]    degrees,
	// result output
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COILS_W-1:0]  coils,
	output logic                busy_res,
	output logic                last_clockwise,
	output logic                rejected,
	// step_period register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PERIOD_W-1:0] cfg_data
);

	logic [PERIOD_W-1:0] step_period_q;

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic                cw_s1;
	logic [DEG_W-1:0]    deg_s1;

	logic                out_valid_q;
	result_t             res_q;
	result_t             res_d;
	logic                adv;

	// The user must write the register only while idle; unenforced, the block takes every write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= PERIOD_RESET;
		end else if (cfg_valid) begin
			step_period_q <= cfg_data;
		end
	end

	// Advance the held item into the sequencer when the result slot is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register: no reset needed.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= operation;
			cw_s1  <= clockwise;
			deg_s1 <= degrees;
		end
	end

	shm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.operation   (op_s1),
		.clockwise   (cw_s1),
		.degrees     (deg_s1),
		.step_period (step_period_q),
		.res_d       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result of the item that advances; hold it while stalled.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign coils          = res_q.coils;
	assign busy_res       = res_q.busy;
	assign last_clockwise = res_q.last_cw;
	assign rejected       = res_q.rejected;

	// A full input register facing a stalled result must not take another item.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");

	// A refused start only happens while a move is running.
	a_reject_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rejected |-> res_q.busy)
		else $error("start rejected while idle");

	// Idle always means the coils are switched off.
	a_idle_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.busy |-> res_q.coils == '0)
		else $error("coils driven while idle");

endmodule

// File: tb/testbench.sv
// Self-checking bench for the half-step angle mover: driver, predictor, result monitor.
`timescale 1ns / 1ps

module testbench;
	import shm_pkg::*;

	// Operation code the block ignores.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int STEPS_PER_TURN = 512;
	localparam int DEG_PER_TURN   = 360;
	// Half-step patterns, phase 0 in the low nibble.
	localparam logic [31:0] CW_PATTERNS  = 32'h98C46231;
	localparam logic [31:0] CCW_PATTERNS = 32'h913264C8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_CAP  = 100;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             cw;
		logic [DEG_W-1:0] deg;
	} motor_cmd_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     operation = OP_TICK;
	logic                clockwise = 1'b0;
	logic [DEG_W-1:0]    degrees = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COILS_W-1:0]  coils;
	logic                busy_res;
	logic                last_clockwise;
	logic                rejected;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data = '0;

	// Commands waiting for the driver, and coil results owed by the block.
	motor_cmd_t cmds_to_send[$];
	result_t    coil_results_due[$];
	int         cmds_queued = 0;
	int         error_count = 0;
	int         cycle_count = 0;
	int         sender_idle_pct = 0;
	int         receiver_idle_pct = 0;

	// Predicted motor state.
	logic [PERIOD_W-1:0] drv_period = PERIOD_RESET;
	logic [PHASE_W-1:0]  drv_phase = '0;
	logic [15:0]         drv_cycles_left = '0;
	logic [TICK_W-1:0]   drv_ticks = '0;
	mode_t               drv_mode = MODE_IDLE;
	logic                drv_dir = 1'b1;
	logic                drv_last_cw = 1'b1;
	logic [COILS_W-1:0]  drv_coils = '0;

	stepper_half_step_angle_mover i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.clockwise      (clockwise),
		.degrees        (degrees),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.coils          (coils),
		.busy_res       (busy_res),
		.last_clockwise (last_clockwise),
		.rejected       (rejected),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [COILS_W-1:0] phase_coils(input logic dir,
	                                                  input logic [PHASE_W-1:0] idx);
		return dir ? CW_PATTERNS[idx*4 +: 4] : CCW_PATTERNS[idx*4 +: 4];
	endfunction

	// Drop the coils and clear the move counters.
	function automatic void park_motor();
		drv_coils = '0;
		drv_mode = MODE_IDLE;
		drv_phase = '0;
		drv_cycles_left = '0;
		drv_ticks = '0;
	endfunction

	// Advance the predicted motor by one command and return the result it shows.
	function automatic result_t predict_coil_step(input motor_cmd_t cmd);
		result_t res;
		logic    rej;
		rej = 1'b0;
		case (cmd.op)
			OP_TICK: begin
				if (drv_mode == MODE_STEP) begin
					drv_ticks = drv_ticks + 1'b1;
					// A zero period advances on every tick, same as one.
					if (drv_ticks >= drv_period) begin
						drv_ticks = '0;
						if (drv_phase == LAST_PHASE) begin
							drv_cycles_left = drv_cycles_left - 1'b1;
							// Last cycle done: hold the final pattern for the settle.
							if (drv_cycles_left == 0) begin
								drv_mode = MODE_SETTLE;
							end else begin
								drv_phase = '0;
								drv_coils = phase_coils(drv_dir, drv_phase);
							end
						end else begin
							drv_phase = drv_phase + 1'b1;
							drv_coils = phase_coils(drv_dir, drv_phase);
						end
					end
				end else if (drv_mode == MODE_SETTLE) begin
					drv_ticks = drv_ticks + 1'b1;
					if (drv_ticks >= SETTLE_TICKS) begin
						drv_last_cw = drv_dir;
						park_motor();
					end
				end
			end
			OP_START: begin
				// Ignore and flag a start while a move or settle is running.
				if (drv_mode != MODE_IDLE) begin
					rej = 1'b1;
				end else begin
					drv_dir = cmd.cw;
					drv_cycles_left = 16'((STEPS_PER_TURN * int'(cmd.deg)) / DEG_PER_TURN + 1);
					drv_phase = '0;
					drv_ticks = '0;
					drv_mode = MODE_STEP;
					drv_coils = phase_coils(cmd.cw, '0);
				end
			end
			// An aborted move keeps the last completed direction.
			OP_STOP: park_motor();
			default: ;
		endcase
		res.coils = drv_coils;
		res.busy = (drv_mode != MODE_IDLE);
		res.last_cw = drv_last_cw;
		res.rejected = rej;
		return res;
	endfunction

	function automatic void push_cmd(input logic [OP_W-1:0] op, input logic cw,
	                                 input logic [DEG_W-1:0] deg);
		motor_cmd_t cmd;
		cmd.op = op;
		cmd.cw = cw;
		cmd.deg = deg;
		cmds_to_send.push_back(cmd);
		cmds_queued++;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			// Cap the reports so a broken block cannot flood the log.
			if (error_count < REPORT_CAP)
				$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Hold until every command is sent and every result is in, then let the pipe settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (cmds_to_send.size() != 0 || in_valid || coil_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write step_period over its own channel.
	task automatic write_step_period(input logic [PERIOD_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		drv_period = value;
	endtask

	// Driver: present the next command once the current one is taken,
	// predicting its result at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_TICK;
			clockwise <= 1'b0;
			degrees <= '0;
		end else begin
			motor_cmd_t sent;
			motor_cmd_t nxt;
			logic       taken;
			taken = in_valid && in_ready;
			if (taken) begin
				sent.op = operation;
				sent.cw = clockwise;
				sent.deg = degrees;
				coil_results_due.push_back(predict_coil_step(sent));
			end
			if (!in_valid || taken) begin
				if (cmds_to_send.size() != 0 &&
				    $urandom_range(0, 99) >= sender_idle_pct) begin
					nxt = cmds_to_send.pop_front();
					in_valid <= 1'b1;
					operation <= nxt.op;
					clockwise <= nxt.cw;
					degrees <= nxt.deg;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest prediction; stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			result_t want;
			if (out_valid && out_ready) begin
				if (coil_results_due.size() == 0) begin
					if (error_count < REPORT_CAP)
						$error("result with none expected: coils %0h busy %0b",
						       coils, busy_res);
					error_count++;
				end else begin
					want = coil_results_due.pop_front();
					check_field("coils", want.coils, coils);
					check_field("busy_res", want.busy, busy_res);
					check_field("last_clockwise", want.last_cw, last_clockwise);
					check_field("rejected", want.rejected, rejected);
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	initial begin
		int               roll;
		int               deg;
		int               need;
		int               n_ticks;
		int               room;
		int               budget;
		int               budget_end;
		logic             cw;
		logic             finish_move;
		logic [PERIOD_W-1:0] period;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at period 1, sender and receiver both idling.
		sender_idle_pct = 34;
		receiver_idle_pct = 57;
		write_step_period(8'd1);
		push_cmd(OP_TICK, 1'b1, 12'hFFF);       // tick while idle
		push_cmd(OP_STOP, 1'b0, 12'h000);       // stop while idle
		push_cmd(OP_NONE, 1'b1, 12'hFFF);       // unused code while idle
		push_cmd(OP_START, 1'b0, 12'hFFF);      // widest angle, anticlockwise
		push_cmd(OP_TICK, 1'b0, 12'h000);
		push_cmd(OP_TICK, 1'b1, 12'h555);
		push_cmd(OP_START, 1'b1, 12'h000);      // start while busy
		push_cmd(OP_NONE, 1'b0, 12'hAAA);       // unused code while busy
		push_cmd(OP_TICK, 1'b0, 12'h000);
		push_cmd(OP_STOP, 1'b1, 12'hFFF);       // abort mid move
		push_cmd(OP_TICK, 1'b0, 12'h000);
		push_cmd(OP_START, 1'b1, 12'h000);      // zero degrees, clockwise
		repeat (9) push_cmd(OP_TICK, 1'b0, 12'h000);
		push_cmd(OP_START, 1'b0, 12'hFFF);      // start while still busy
		push_cmd(OP_STOP, 1'b0, 12'h000);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: begin period = 8'd1;   budget = 300; end
				1: begin period = 8'd0;   budget = 150; end
				2: begin period = 8'd255; budget = 150; end
				3: begin period = 8'd2;   budget = 200; end
				4: begin period = 8'd7;   budget = 150; end
				default: begin period = 8'd1; budget = 100; end
			endcase
			// Swap the idling sides mid run, then run flat out.
			if (ph < 2) begin
				sender_idle_pct = 34;
				receiver_idle_pct = 57;
			end else if (ph < 4) begin
				sender_idle_pct = 57;
				receiver_idle_pct = 34;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_step_period(period);

			// Mostly whole moves with random content; some noise and aborted moves.
			budget_end = cmds_queued + budget;
			while (cmds_queued < budget_end) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					push_cmd(OP_W'($urandom_range(0, 3)), 1'($urandom), DEG_W'($urandom));
				end else begin
					cw = 1'($urandom);
					roll = $urandom_range(0, 99);
					if (roll < 60)
						deg = $urandom_range(0, 2);
					else if (roll < 75)
						deg = $urandom_range(0, 45);
					else
						deg = $urandom_range(0, 4095);
					need = ((STEPS_PER_TURN * deg) / DEG_PER_TURN + 1) * 8 *
					       (period == 0 ? 1 : int'(period)) + int'(SETTLE_TICKS);
					finish_move = (need <= 400) && ($urandom_range(0, 99) < 75);
					if (finish_move)
						n_ticks = need + $urandom_range(0, 4);
					else
						n_ticks = $urandom_range(1, need < 250 ? need : 250);
					// Cut a move that would overrun the phase budget and abort it instead.
					room = budget_end - cmds_queued - 2;
					if (n_ticks > room) begin
						n_ticks = (room > 0) ? room : 0;
						finish_move = 1'b0;
					end
					push_cmd(OP_START, cw, DEG_W'(deg));
					repeat (n_ticks) begin
						roll = $urandom_range(0, 99);
						if (roll < 3)
							push_cmd(OP_START, 1'($urandom), DEG_W'($urandom));
						else if (roll < 5)
							push_cmd(OP_NONE, 1'($urandom), DEG_W'($urandom));
						else
							push_cmd(OP_TICK, 1'($urandom), DEG_W'($urandom));
					end
					if (!finish_move)
						push_cmd(OP_STOP, 1'($urandom), DEG_W'($urandom));
				end
			end
		end

		wait_drained();
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
